// File: rtl/fwbp_pkg.sv
package fwbp_pkg;

  localparam int ACC_W      = 24;
  localparam int CNT_W      = 5;
  localparam int WIDTH_W    = 5;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [7:0]         BYTE_MASK   = 8'hFF;
  localparam logic [CNT_W-1:0]   BYTE_BITS   = 5'd8;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 5'd16;

  localparam logic [CFG_ADDR_W-1:0] REG_MODE  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WIDTH = 1'd1;

  typedef enum logic {
    MODE_PACK   = 1'b0,
    MODE_UNPACK = 1'b1
  } mode_t;

  typedef struct packed {
    logic [15:0] data;
    logic        last;
    logic [2:0]  tail_pad;
  } item_t;

  typedef struct packed {
    logic [15:0] data_res;
    logic        last_res;
  } res_t;

  // Ones in the low n bits of the accumulator.
  function automatic logic [ACC_W-1:0] low_mask(input logic [CNT_W-1:0] n);
    low_mask = ~({ACC_W{1'b1}} << n);
  endfunction

endpackage

// File: rtl/fwbp_core.sv
module fwbp_core (
  input  logic                          clk,
  input  logic                          rst,
  input  fwbp_pkg::mode_t               mode,
  input  logic [fwbp_pkg::WIDTH_W-1:0]  width,
  input  logic                          clear,
  input  logic                          item_valid,
  input  fwbp_pkg::item_t               item,
  output logic                          item_ready,
  input  logic                          out_free,
  output logic                          emit_valid,
  output fwbp_pkg::res_t                emit_res
);

  logic [fwbp_pkg::ACC_W-1:0] acc, acc_next;
  logic [fwbp_pkg::CNT_W-1:0] cnt, cnt_next;
  logic                       fin, fin_next;

  logic                       pack, w_nz, pend, pend1, full;
  logic [fwbp_pkg::CNT_W-1:0] cnt_e, cnt1, cnt2;
  logic [fwbp_pkg::ACC_W-1:0] acc_e, acc1, acc2, shifted;
  logic [7:0]                 byte_val;
  logic [15:0]                val;

  always_comb begin
    pack = (mode == fwbp_pkg::MODE_PACK);
    w_nz = (width != '0);
    pend = pack ? ((cnt >= fwbp_pkg::BYTE_BITS) || (fin && cnt != '0))
                : (w_nz && cnt >= width);

    // Take one result off the oldest bits of the accumulator.
    full = (cnt >= fwbp_pkg::BYTE_BITS);
    if (full) begin
      byte_val = 8'(acc >> (cnt - fwbp_pkg::BYTE_BITS)) & fwbp_pkg::BYTE_MASK;
    end else begin
      byte_val = 8'(acc << (fwbp_pkg::BYTE_BITS - cnt));
    end
    if (pack) begin
      cnt_e = full ? cnt - fwbp_pkg::BYTE_BITS : '0;
      val   = {8'b0, byte_val};
    end else begin
      cnt_e = cnt - width;
      val   = 16'(acc >> cnt_e) & 16'(fwbp_pkg::low_mask(width));
    end
    acc_e = acc & fwbp_pkg::low_mask(cnt_e);

    emit_valid = pend && out_free;
    acc1 = emit_valid ? acc_e : acc;
    cnt1 = emit_valid ? cnt_e : cnt;
    pend1 = pack ? ((cnt1 >= fwbp_pkg::BYTE_BITS) || (fin && cnt1 != '0))
                 : (w_nz && cnt1 >= width);

    emit_res.data_res = val;
    emit_res.last_res = fin && !pend1;

    // A finished stream with nothing left to send starts afresh.
    if (fin && !pend1) begin
      acc2 = '0;
      cnt2 = '0;
    end else begin
      acc2 = acc1;
      cnt2 = cnt1;
    end

    item_ready = !pend1;

    shifted  = {acc2[15:0], item.data[7:0]};
    acc_next = acc2;
    cnt_next = cnt2;
    fin_next = fin && pend1;
    if (item_valid && item_ready) begin
      fin_next = item.last;
      if (w_nz) begin
        if (pack) begin
          acc_next = (acc2 << width) |
                     ({8'b0, item.data} & fwbp_pkg::low_mask(width));
          cnt_next = cnt2 + width;
        end else if (item.last) begin
          acc_next = shifted >> item.tail_pad;
          cnt_next = cnt2 + fwbp_pkg::BYTE_BITS - {2'b0, item.tail_pad};
        end else begin
          acc_next = shifted;
          cnt_next = cnt2 + fwbp_pkg::BYTE_BITS;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      acc <= '0;
      cnt <= '0;
      fin <= 1'b0;
    end else begin
      acc <= acc_next;
      cnt <= cnt_next;
      fin <= fin_next;
    end
  end

endmodule

// File: rtl/fwbp_out_reg.sv
module fwbp_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           emit_valid,
  input  fwbp_pkg::res_t emit_res,
  output logic           out_free,
  output logic           res_valid,
  input  logic           res_ready,
  output fwbp_pkg::res_t res
);

  assign out_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit_valid) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid) begin
      res <= emit_res;
    end
  end

endmodule

// File: rtl/fixed_width_bit_packer_unit.sv
// Channel   Direction  Handshake                  Payload
// config    in         cfg_wr_en                  cfg_addr, cfg_wr_data
// item      in         item_valid / item_ready    item (data, last, tail_pad)
// result    out        res_valid / res_ready      res (data_res, last_res)
//
// An item is taken into the accumulator; while the result register is free,
// its results leave one per cycle into that register, so an item giving one
// result sustains one item per cycle; others hold the input to the last result.
// Reset is synchronous and leaves the block in pack mode at width 16.
// A stalled result register stops the draining of the accumulator; items are
// still taken while the accumulator holds no complete result.
module fixed_width_bit_packer_unit #(
  parameter int ELEM_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [fwbp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [fwbp_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  fwbp_pkg::item_t                   item,
  output logic                              res_valid,
  input  logic                              res_ready,
  output fwbp_pkg::res_t                    res
);

  localparam int WIDTH_CAP = (ELEM_BITS < 16) ? ELEM_BITS : 16;

  fwbp_pkg::mode_t                mode;
  logic [fwbp_pkg::WIDTH_W-1:0]   packed_width;
  logic [fwbp_pkg::WIDTH_W-1:0]   eff_width;
  logic                           out_free;
  logic                           emit_valid;
  fwbp_pkg::res_t                 emit_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= fwbp_pkg::MODE_PACK;
      packed_width <= fwbp_pkg::WIDTH_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        fwbp_pkg::REG_MODE:  mode <= fwbp_pkg::mode_t'(cfg_wr_data[0]);
        fwbp_pkg::REG_WIDTH: packed_width <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  assign eff_width = (packed_width > fwbp_pkg::WIDTH_W'(WIDTH_CAP))
                     ? fwbp_pkg::WIDTH_W'(WIDTH_CAP) : packed_width;

  fwbp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode),
    .width      (eff_width),
    .clear      (cfg_wr_en),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .out_free   (out_free),
    .emit_valid (emit_valid),
    .emit_res   (emit_res)
  );

  fwbp_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .emit_valid (emit_valid),
    .emit_res   (emit_res),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // A result is only produced when the result register can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit_valid |-> out_free)
    else $error("result produced into an occupied result register");

  // A register write empties the accumulator, so the next request is taken.
  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> item_ready)
    else $error("accumulator not empty after a register write");

  // With no new result the register drains once it is free.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_free && !emit_valid |=> !res_valid)
    else $error("result valid without a new result");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
module testbench;

  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RAND_ITEMS   = 200;
  localparam int QUIET_AFTER  = 170;
  localparam int PAUSE_AFTER  = 100;

  localparam fwbp_pkg::res_t NO_RES = '0;

  typedef enum logic {STEP_WRITE, STEP_ITEM} step_kind_t;

  typedef struct {
    step_kind_t                      kind;
    logic [fwbp_pkg::CFG_ADDR_W-1:0] addr;
    logic [fwbp_pkg::CFG_DATA_W-1:0] value;
    fwbp_pkg::item_t                 it;
    int                              n_typed;
    fwbp_pkg::res_t                  r0;
    fwbp_pkg::res_t                  r1;
  } step_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_wr_en = 1'b0;
  logic [fwbp_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [fwbp_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;
  logic                            item_valid = 1'b0;
  logic                            item_ready;
  fwbp_pkg::item_t                 item = '0;
  logic                            res_valid;
  logic                            res_ready = 1'b0;
  fwbp_pkg::res_t                  res;

  // Mirror of the block's configuration and bit accumulator.
  fwbp_pkg::mode_t                 cur_mode = fwbp_pkg::MODE_PACK;
  logic [fwbp_pkg::WIDTH_W-1:0]    cur_width = fwbp_pkg::WIDTH_RESET;
  logic [31:0]                     acc_bits = '0;
  int                              acc_cnt = 0;

  fwbp_pkg::res_t                  owed_res[$];
  fwbp_pkg::res_t                  want;
  step_t                           plan[$];
  int                              errors = 0;
  int                              cycles = 0;
  int                              stall_left = 0;
  bit                              quiet = 1'b0;
  bit                              vld_hi = 1'b0;

  fixed_width_bit_packer_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] ones(input int n);
    return (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
  endfunction

  function automatic fwbp_pkg::res_t rv(input logic [15:0] d, input logic l);
    fwbp_pkg::res_t r;
    r.data_res = d;
    r.last_res = l;
    return r;
  endfunction

  function automatic fwbp_pkg::item_t make_item(input logic last);
    fwbp_pkg::item_t it;
    if ($urandom_range(0, 7) == 0) begin
      it.data = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    end else begin
      it.data = 16'($urandom);
    end
    it.last = last;
    it.tail_pad = 3'($urandom_range(0, 7));
    return it;
  endfunction

  task automatic flag(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  // Advances the mirrored accumulator by one request and, unless the
  // results were typed in by hand, queues the words it should produce.
  task automatic advance_packer(input fwbp_pkg::item_t it, input bit typed);
    int             w;
    fwbp_pkg::res_t r;
    fwbp_pkg::res_t got[$];
    w = (cur_width > 16) ? 16 : int'(cur_width);
    if (w != 0) begin
      if (cur_mode == fwbp_pkg::MODE_PACK) begin
        acc_bits = ((acc_bits << w) | (32'(it.data) & ones(w))) & 32'h00FF_FFFF;
        acc_cnt += w;
        while (acc_cnt >= 8) begin
          acc_cnt -= 8;
          got.push_back(rv(16'((acc_bits >> acc_cnt) & 32'(fwbp_pkg::BYTE_MASK)),
                           1'b0));
          acc_bits &= ones(acc_cnt);
        end
        // The flushed byte carries its padding in the low bits.
        if (it.last && acc_cnt > 0) begin
          got.push_back(rv(16'((acc_bits << (8 - acc_cnt)) &
                               32'(fwbp_pkg::BYTE_MASK)), 1'b0));
        end
      end else begin
        acc_bits = ((acc_bits << 8) | 32'(it.data[7:0])) & 32'h00FF_FFFF;
        acc_cnt += 8;
        if (it.last) begin
          acc_bits = acc_bits >> it.tail_pad;
          acc_cnt -= int'(it.tail_pad);
        end
        while (acc_cnt >= w && got.size() < 8) begin
          acc_cnt -= w;
          got.push_back(rv(16'((acc_bits >> acc_cnt) & ones(w)), 1'b0));
          acc_bits &= ones(acc_cnt);
        end
      end
    end
    if (it.last) begin
      if (got.size() > 0) begin
        r = got.pop_back();
        r.last_res = 1'b1;
        got.push_back(r);
      end
      acc_bits = '0;
      acc_cnt = 0;
    end
    if (!typed) begin
      foreach (got[i]) owed_res.push_back(got[i]);
    end
  endtask

  task automatic drop_valid();
    if (vld_hi) begin
      item_valid <= 1'b0;
      vld_hi = 1'b0;
    end
  endtask

  // A negative n_typed leaves the expected words to the predictor.
  task automatic send_item(input fwbp_pkg::item_t it, input int n_typed,
                           input fwbp_pkg::res_t r0, input fwbp_pkg::res_t r1);
    item <= it;
    item_valid <= 1'b1;
    vld_hi = 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    advance_packer(it, n_typed >= 0);
    if (n_typed > 0) owed_res.push_back(r0);
    if (n_typed > 1) owed_res.push_back(r1);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      vld_hi = 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic settle();
    drop_valid();
    while (owed_res.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fwbp_pkg::CFG_ADDR_W-1:0] a,
                           input logic [fwbp_pkg::CFG_DATA_W-1:0] v);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_addr <= a;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (a == fwbp_pkg::REG_MODE) begin
      cur_mode = fwbp_pkg::mode_t'(v[0]);
    end else if (a == fwbp_pkg::REG_WIDTH) begin
      cur_width = v;
    end
    acc_bits = '0;
    acc_cnt = 0;
  endtask

  task automatic add_write(input logic [fwbp_pkg::CFG_ADDR_W-1:0] a,
                           input logic [fwbp_pkg::CFG_DATA_W-1:0] v);
    step_t s;
    s.kind = STEP_WRITE;
    s.addr = a;
    s.value = v;
    s.it = '0;
    s.n_typed = 0;
    s.r0 = '0;
    s.r1 = '0;
    plan.push_back(s);
  endtask

  task automatic add_item(input logic [15:0] d, input logic l, input logic [2:0] pad,
                          input int n, input fwbp_pkg::res_t r0,
                          input fwbp_pkg::res_t r1);
    step_t s;
    s.kind = STEP_ITEM;
    s.addr = '0;
    s.value = '0;
    s.it.data = d;
    s.it.last = l;
    s.it.tail_pad = pad;
    s.n_typed = n;
    s.r0 = r0;
    s.r1 = r1;
    plan.push_back(s);
  endtask

  always @(posedge clk) begin
    if (rst || quiet) begin
      res_ready <= 1'b1;
    end else if (stall_left > 0) begin
      res_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      res_ready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      res_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (owed_res.size() == 0) begin
        flag($sformatf("unexpected result data_res=%h last_res=%b",
                       res.data_res, res.last_res));
      end else begin
        want = owed_res.pop_front();
        if (res.data_res !== want.data_res) begin
          flag($sformatf("data_res got %h want %h", res.data_res, want.data_res));
        end
        if (res.last_res !== want.last_res) begin
          flag($sformatf("last_res got %b want %b", res.last_res, want.last_res));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[fixed_width_bit_packer_unit] ERROR");
      $finish;
    end
  end

  initial begin
    step_t                        s;
    int                           counted;
    int                           n_streams;
    int                           len;
    int                           k;
    bit                           pressed;
    fwbp_pkg::mode_t              m;
    logic [fwbp_pkg::WIDTH_W-1:0] wv;

    // Pack mode at the reset width of 16.
    add_item(16'hA5C3, 1'b0, 3'd0, 2, rv(16'h00A5, 1'b0), rv(16'h00C3, 1'b0));
    add_item(16'hFFFF, 1'b1, 3'd7, 2, rv(16'h00FF, 1'b0), rv(16'h00FF, 1'b1));
    add_item(16'h0000, 1'b1, 3'd0, 2, rv(16'h0000, 1'b0), rv(16'h0000, 1'b1));
    add_write(fwbp_pkg::REG_WIDTH, 5'd0);
    add_item(16'hFFFF, 1'b1, 3'd0, 0, NO_RES, NO_RES);
    // A width above 16 saturates.
    add_write(fwbp_pkg::REG_WIDTH, 5'd31);
    add_item(16'h1234, 1'b1, 3'd0, 2, rv(16'h0012, 1'b0), rv(16'h0034, 1'b1));
    add_write(fwbp_pkg::REG_WIDTH, 5'd3);
    add_item(16'hFFFF, 1'b0, 3'd2, -1, NO_RES, NO_RES);
    add_item(16'h0005, 1'b0, 3'd0, -1, NO_RES, NO_RES);
    add_item(16'h0002, 1'b1, 3'd5, -1, NO_RES, NO_RES);
    add_write(fwbp_pkg::REG_WIDTH, 5'd1);
    add_item(16'hFFFE, 1'b0, 3'd0, -1, NO_RES, NO_RES);
    add_item(16'h0001, 1'b0, 3'd0, -1, NO_RES, NO_RES);
    add_item(16'h0001, 1'b1, 3'd0, -1, NO_RES, NO_RES);
    add_write(fwbp_pkg::REG_WIDTH, 5'd8);
    add_item(16'h00AB, 1'b1, 3'd0, 1, rv(16'h00AB, 1'b1), NO_RES);
    // Unpack mode; the upper byte of data must be ignored.
    add_write(fwbp_pkg::REG_MODE, 5'(fwbp_pkg::MODE_UNPACK));
    add_item(16'hFF5A, 1'b1, 3'd0, 1, rv(16'h005A, 1'b1), NO_RES);
    add_write(fwbp_pkg::REG_WIDTH, 5'd1);
    add_item(16'h00B7, 1'b0, 3'd0, -1, NO_RES, NO_RES);
    add_item(16'h00FF, 1'b1, 3'd7, -1, NO_RES, NO_RES);
    add_write(fwbp_pkg::REG_WIDTH, 5'd16);
    add_item(16'h0012, 1'b0, 3'd0, 0, NO_RES, NO_RES);
    add_item(16'h0034, 1'b1, 3'd0, 1, rv(16'h1234, 1'b1), NO_RES);
    // A final byte too short for a field gives no result at all.
    add_item(16'h0012, 1'b1, 3'd0, 0, NO_RES, NO_RES);
    add_write(fwbp_pkg::REG_WIDTH, 5'd5);
    add_item(16'h00C6, 1'b0, 3'd0, -1, NO_RES, NO_RES);
    add_item(16'h0039, 1'b1, 3'd3, -1, NO_RES, NO_RES);
    add_write(fwbp_pkg::REG_WIDTH, 5'd0);
    add_item(16'h00FF, 1'b1, 3'd0, 0, NO_RES, NO_RES);
    // A write in the middle of a stream drops the leftover bits.
    add_write(fwbp_pkg::REG_WIDTH, 5'd3);
    add_item(16'h00E4, 1'b0, 3'd0, -1, NO_RES, NO_RES);
    add_write(fwbp_pkg::REG_WIDTH, 5'd3);
    add_item(16'h00E4, 1'b1, 3'd0, -1, NO_RES, NO_RES);
    add_write(fwbp_pkg::REG_MODE, 5'(fwbp_pkg::MODE_PACK));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      s = plan[i];
      if (s.kind == STEP_WRITE) begin
        write_reg(s.addr, s.value);
      end else begin
        send_item(s.it, s.n_typed, s.r0, s.r1);
      end
    end

    counted = 0;
    pressed = 1'b0;
    while (counted < RAND_ITEMS) begin
      m = fwbp_pkg::mode_t'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0: wv = 5'd0;
        1: wv = 5'd1;
        2: wv = 5'd8;
        3: wv = 5'd16;
        4: wv = 5'd31;
        5: wv = 5'($urandom_range(17, 31));
        default: wv = 5'($urandom_range(1, 16));
      endcase
      if ($urandom_range(0, 1) != 0) begin
        write_reg(fwbp_pkg::REG_MODE, {4'($urandom), m});
        write_reg(fwbp_pkg::REG_WIDTH, wv);
      end else begin
        write_reg(fwbp_pkg::REG_WIDTH, wv);
        write_reg(fwbp_pkg::REG_MODE, {4'($urandom), m});
      end
      n_streams = (wv == 0) ? 1 : $urandom_range(1, 4);
      repeat (n_streams) begin
        if (wv == 0) begin
          len = $urandom_range(1, 3);
        end else begin
          len = $urandom_range(1, (m == fwbp_pkg::MODE_PACK) ? 6 : 10);
        end
        // Most streams end properly; a few run on into the next one.
        for (k = 0; k < len; k++) begin
          send_item(make_item((k == len - 1) && ($urandom_range(0, 7) != 0)),
                    -1, NO_RES, NO_RES);
        end
        if (wv != 0) counted += len;
        quiet = (counted >= QUIET_AFTER);
        if (!pressed && counted >= PAUSE_AFTER) begin
          drop_valid();
          @(posedge clk);
          while (owed_res.size() != 0) @(posedge clk);
          pressed = 1'b1;
        end
      end
    end

    settle();
    if (errors == 0) begin
      $display("[fixed_width_bit_packer_unit] OK");
    end else begin
      $display("[fixed_width_bit_packer_unit] ERROR");
    end
    $finish;
  end

endmodule
